// ===== hw/rtl/csm_pkg.sv =====
`default_nettype none

package csm_pkg;

	localparam int unsigned QDEPTH = 4;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [7:0] masked_byte;
		logic       final_byte;
	} out_word_t;

	typedef struct packed {
		logic [1:0] n;
		out_word_t  w0;
		out_word_t  w1;
	} push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/comment_string_masker_unit.sv =====
// Masks comments and string literals in a byte stream of source text.
// The text channel takes one word per cycle: a byte and an end-of-text mark.
// The masked channel returns one word per byte, the byte itself or a space
// where it lies inside a comment or a string; line breaks are always kept.
// The last word of a text carries final_byte.
// An opening slash, a star inside a block comment and a backslash inside a
// string are held back until the next byte shows what they start, so one
// input word can release zero, one or two output words.
// An accepted text word is registered in the input stage, and the words it
// releases are written to the output queue, which presents them in order.
// Throughput is one word per cycle in both directions; the input may stall
// when the four-entry output queue lacks room for two words.
// Reset clears the scanner to code mode, drops any held byte and empties
// the output queue. When the receiver stalls, the queue fills and then the
// text channel stalls; no word is lost and the presented word holds steady.
`default_nettype none

module comment_string_masker_unit
	import csm_pkg::*;
#(
	parameter int unsigned DEPTH = QDEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      text_valid,
	output logic           text_stall,
	input  wire in_word_t  text,
	output logic           masked_valid,
	input  wire logic      masked_stall,
	output out_word_t      masked
);

	push_t push;
	logic  room;

	csm_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.room       (room),
		.push       (push)
	);

	csm_queue #(.DEPTH(DEPTH)) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.masked_valid (masked_valid),
		.masked_stall (masked_stall),
		.masked       (masked)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/csm_scan.sv =====
`default_nettype none

module csm_scan
	import csm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     text_valid,
	output logic          text_stall,
	input  wire in_word_t text,
	input  wire logic     room,
	output push_t         push
);

	typedef enum logic [3:0] {
		M_CODE  = 4'b0001,
		M_LINE  = 4'b0010,
		M_BLOCK = 4'b0100,
		M_STR   = 4'b1000
	} mode_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] b;
		mode_t      mode;
		logic       qs;
		logic       hold;
	} fresh_t;

	function automatic logic is_break(input logic [7:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic fresh_t take_fresh(input logic [7:0] c, input logic last,
		input mode_t mode, input logic qs);
		fresh_t     f;
		logic [7:0] q;
		f.emit = 1'b0;
		f.b    = CH_SPACE;
		f.mode = mode;
		f.qs   = qs;
		f.hold = 1'b0;
		q      = qs ? CH_SQUOTE : CH_DQUOTE;
		unique case (mode)
			M_LINE: begin
				f.emit = 1'b1;
				if (is_break(c)) begin
					f.mode = M_CODE;
					f.b    = c;
				end
			end
			M_BLOCK: begin
				if (c == CH_STAR && !last) begin
					f.hold = 1'b1;
				end else begin
					f.emit = 1'b1;
					f.b    = is_break(c) ? c : CH_SPACE;
				end
			end
			M_STR: begin
				if (c == CH_BSLASH && !last) begin
					f.hold = 1'b1;
				end else if (c == q) begin
					f.emit = 1'b1;
					f.mode = M_CODE;
				end else begin
					f.emit = 1'b1;
					f.b    = is_break(c) ? c : CH_SPACE;
				end
			end
			default: begin
				if (c == CH_SLASH && !last) begin
					f.hold = 1'b1;
				end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
					f.emit = 1'b1;
					f.qs   = (c == CH_SQUOTE);
					f.mode = M_STR;
				end else begin
					f.emit = 1'b1;
					f.b    = c;
				end
			end
		endcase
		return f;
	endfunction

	logic       valid_s1;
	in_word_t   word_s1;
	mode_t      mode_q, mode_n;
	logic       qs_q, qs_n;
	logic       held_q, held_n;
	logic [7:0] held_byte_q;
	logic       go;
	fresh_t     f;
	logic [7:0] c;
	logic       last;

	assign go         = valid_s1 && room;
	assign text_stall = valid_s1 && !room;
	assign c          = word_s1.text_byte;
	assign last       = word_s1.end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall && text_valid) begin
			word_s1 <= text;
		end
	end

	always_comb begin
		push   = '0;
		mode_n = mode_q;
		qs_n   = qs_q;
		held_n = 1'b0;
		f      = take_fresh(c, last, mode_q, qs_q);
		if (held_q) begin
			unique case (mode_q)
				M_BLOCK: begin
					push.w0.masked_byte = CH_SPACE;
					if (c == CH_SLASH) begin
						push.n              = 2'd2;
						push.w1.masked_byte = CH_SPACE;
						mode_n              = M_CODE;
					end else begin
						push.n              = f.emit ? 2'd2 : 2'd1;
						push.w1.masked_byte = f.b;
						mode_n              = f.mode;
						qs_n                = f.qs;
						held_n              = f.hold;
					end
				end
				M_STR: begin
					push.n              = 2'd2;
					push.w0.masked_byte = CH_SPACE;
					push.w1.masked_byte = is_break(c) ? c : CH_SPACE;
				end
				default: begin
					if (mode_q == M_CODE && (c == CH_SLASH || c == CH_STAR)) begin
						push.n              = 2'd2;
						push.w0.masked_byte = CH_SPACE;
						push.w1.masked_byte = CH_SPACE;
						mode_n              = (c == CH_SLASH) ? M_LINE : M_BLOCK;
					end else begin
						push.w0.masked_byte = held_byte_q;
						push.n              = f.emit ? 2'd2 : 2'd1;
						push.w1.masked_byte = f.b;
						mode_n              = f.mode;
						qs_n                = f.qs;
						held_n              = f.hold;
					end
				end
			endcase
		end else begin
			push.n              = f.emit ? 2'd1 : 2'd0;
			push.w0.masked_byte = f.b;
			mode_n              = f.mode;
			qs_n                = f.qs;
			held_n              = f.hold;
		end
		if (last) begin
			push.w0.final_byte = (push.n == 2'd1);
			push.w1.final_byte = (push.n == 2'd2);
			mode_n             = M_CODE;
			qs_n               = 1'b0;
			held_n             = 1'b0;
		end
		if (!go) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_CODE;
			qs_q   <= 1'b0;
			held_q <= 1'b0;
		end else if (go) begin
			mode_q <= mode_n;
			qs_q   <= qs_n;
			held_q <= held_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go && held_n) begin
			held_byte_q <= c;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go && last) |=> (!held_q && mode_q == M_CODE && !qs_q))
		else $error("state not cleared after the final word");

	a_no_hold_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> (mode_q != M_LINE))
		else $error("byte held in line comment");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("push without queue room");

endmodule

`default_nettype wire

// ===== hw/rtl/csm_queue.sv =====
`default_nettype none

module csm_queue
	import csm_pkg::*;
#(
	parameter int unsigned DEPTH = QDEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       masked_valid,
	input  wire logic  masked_stall,
	output out_word_t  masked
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	out_word_t         mem [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     count_q;
	logic              pop;

	assign masked_valid = (count_q != '0);
	assign masked       = mem[rd_q];
	assign pop          = masked_valid && !masked_stall;
	assign room         = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(push.n);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.w0;
		end
		if (push.n == 2'd2) begin
			mem[wr_q + AW'(1)] <= push.w1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue overflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd0 && !pop) |=> $stable(count_q))
		else $error("queue count moved without push or pop");

	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("push while the queue lacks room");

endmodule

`default_nettype wire
